[design/ffdl_pkg.sv]
// Shared types, codes and control word layout for the flanger delay line.
package ffdl_pkg;

  localparam int SAMP_W  = 16;
  localparam int DELAY_W = 18;
  localparam int ACC_W   = 36;
  localparam int OP1_W   = 17;
  localparam int OP2_W   = 18;

  localparam logic signed [SAMP_W-1:0] FB_LIMIT = 16'sd31129;
  localparam logic [SAMP_W:0]          MIX_ONE  = 17'd32768;
  localparam int                       DMIN     = 256;

  typedef enum logic [0:0] {
    REG_FEEDBACK_GAIN = 1'b0,
    REG_MIX_LEVEL     = 1'b1
  } cfg_reg_t;

  // microprogram step addresses
  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_CLAMP = 4'd1,
    ST_POS   = 4'd2,
    ST_RDA   = 4'd3,
    ST_RDB   = 4'd4,
    ST_MACB  = 4'd5,
    ST_FB    = 4'd6,
    ST_STORE = 4'd7,
    ST_MIX   = 4'd8,
    ST_OUT   = 4'd9
  } step_t;

  // jump conditions
  typedef enum logic [1:0] {
    JC_ALWAYS,   // go to target
    JC_IN,       // go to target once a request is taken, else hold
    JC_OUT       // go to target once the output register is free, else hold
  } jc_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_BASE,
    RD_NEXT
  } rd_t;

  typedef enum logic [1:0] {
    RND_0,
    RND_128,
    RND_16K
  } rnd_t;

  typedef enum logic [1:0] {
    OP1_RAM,      // memory read data, zero if entry never written
    OP1_ACC_DLY,  // acc >>> 8 (interpolated sample)
    OP1_DLY,      // latched delayed sample
    OP1_X         // input sample
  } op1_t;

  typedef enum logic [2:0] {
    OP2_INVF,
    OP2_FRAC,
    OP2_FB,
    OP2_DRY,
    OP2_WET
  } op2_t;

  typedef struct packed {
    jc_t   jc;
    step_t tgt;
    logic  ld_dc;
    logic  ld_pos;
    rd_t   rd;
    logic  mac;
    logic  acc_clr;
    rnd_t  rnd;
    op1_t  op1;
    op2_t  op2;
    logic  ld_dly;
    logic  wr_mem;
    logic  ld_out;
  } ctl_word_t;

  localparam ctl_word_t CTL_NOP = '{
    jc: JC_ALWAYS, tgt: ST_IDLE, ld_dc: 1'b0, ld_pos: 1'b0, rd: RD_NONE,
    mac: 1'b0, acc_clr: 1'b0, rnd: RND_0, op1: OP1_RAM, op2: OP2_INVF,
    ld_dly: 1'b0, wr_mem: 1'b0, ld_out: 1'b0
  };

endpackage

[design/ffdl_ram.sv]
// Delay memory: one write port, one registered read port.
module ffdl_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [ffdl_pkg::SAMP_W-1:0] wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic signed [ffdl_pkg::SAMP_W-1:0] rdata
);

  logic signed [ffdl_pkg::SAMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ffdl_seq.sv]
// Microprogram sequencer: step counter, control ROM and conditional jumps.
module ffdl_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_busy,
  output ffdl_pkg::ctl_word_t ctl
);

  ffdl_pkg::step_t step, step_next;

  always_comb begin
    ctl = ffdl_pkg::CTL_NOP;
    case (step)
      ffdl_pkg::ST_IDLE: begin
        ctl.jc  = ffdl_pkg::JC_IN;
        ctl.tgt = ffdl_pkg::ST_CLAMP;
      end
      ffdl_pkg::ST_CLAMP: begin
        ctl.tgt   = ffdl_pkg::ST_POS;
        ctl.ld_dc = 1'b1;
      end
      ffdl_pkg::ST_POS: begin
        ctl.tgt    = ffdl_pkg::ST_RDA;
        ctl.ld_pos = 1'b1;
      end
      ffdl_pkg::ST_RDA: begin
        ctl.tgt = ffdl_pkg::ST_RDB;
        ctl.rd  = ffdl_pkg::RD_BASE;
      end
      ffdl_pkg::ST_RDB: begin
        ctl.tgt     = ffdl_pkg::ST_MACB;
        ctl.rd      = ffdl_pkg::RD_NEXT;
        ctl.mac     = 1'b1;
        ctl.acc_clr = 1'b1;
        ctl.rnd     = ffdl_pkg::RND_128;
        ctl.op1     = ffdl_pkg::OP1_RAM;
        ctl.op2     = ffdl_pkg::OP2_INVF;
      end
      ffdl_pkg::ST_MACB: begin
        ctl.tgt = ffdl_pkg::ST_FB;
        ctl.mac = 1'b1;
        ctl.op1 = ffdl_pkg::OP1_RAM;
        ctl.op2 = ffdl_pkg::OP2_FRAC;
      end
      ffdl_pkg::ST_FB: begin
        ctl.tgt     = ffdl_pkg::ST_STORE;
        ctl.ld_dly  = 1'b1;
        ctl.mac     = 1'b1;
        ctl.acc_clr = 1'b1;
        ctl.rnd     = ffdl_pkg::RND_16K;
        ctl.op1     = ffdl_pkg::OP1_ACC_DLY;
        ctl.op2     = ffdl_pkg::OP2_FB;
      end
      ffdl_pkg::ST_STORE: begin
        ctl.tgt     = ffdl_pkg::ST_MIX;
        ctl.wr_mem  = 1'b1;
        ctl.mac     = 1'b1;
        ctl.acc_clr = 1'b1;
        ctl.rnd     = ffdl_pkg::RND_16K;
        ctl.op1     = ffdl_pkg::OP1_X;
        ctl.op2     = ffdl_pkg::OP2_DRY;
      end
      ffdl_pkg::ST_MIX: begin
        ctl.tgt = ffdl_pkg::ST_OUT;
        ctl.mac = 1'b1;
        ctl.op1 = ffdl_pkg::OP1_DLY;
        ctl.op2 = ffdl_pkg::OP2_WET;
      end
      ffdl_pkg::ST_OUT: begin
        ctl.jc     = ffdl_pkg::JC_OUT;
        ctl.tgt    = ffdl_pkg::ST_IDLE;
        ctl.ld_out = 1'b1;
      end
      default: begin
        ctl.tgt = ffdl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    step_next = step;
    case (ctl.jc)
      ffdl_pkg::JC_ALWAYS: step_next = ctl.tgt;
      ffdl_pkg::JC_IN:     if (in_valid) step_next = ctl.tgt;
      ffdl_pkg::JC_OUT:    if (!out_busy) step_next = ctl.tgt;
      default:             step_next = ffdl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ffdl_pkg::ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[design/feedback_flanger_delay_line.sv]
// Flanger delay line: clamped fractional delay, linear interpolation, feedback, dry/wet mix.
// A request runs through the steps CLAMP, POS, RDA, RDB, MACB, FB, STORE, MIX and OUT before out_valid rises.
// One sample at a time runs through the ten-step microprogram on one MAC unit; requests are taken only in ST_IDLE.
// The output register lets the next sample start while a result waits to be taken.
// Reset (rst, synchronous): write pointer zero, memory reads as zero until written
// (wrap flag, no clearing pass), feedback_gain 0, mix_level 16384.
module feedback_flanger_delay_line #(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ffdl_pkg::SAMP_W-1:0]     in_sample,
  input  logic [ffdl_pkg::DELAY_W-1:0]           delay_q8,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ffdl_pkg::SAMP_W-1:0]     out_sample,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  ffdl_pkg::cfg_reg_t                     cfg_index,
  input  logic [ffdl_pkg::SAMP_W-1:0]            cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int CW = (AW + 8 > ffdl_pkg::DELAY_W) ? AW + 8 : ffdl_pkg::DELAY_W;
  localparam int PW = AW + 9;
  localparam logic [CW-1:0] DMAX     = CW'((DELAY_DEPTH - 2) * 256);
  localparam logic [CW-1:0] DMIN_C   = CW'(ffdl_pkg::DMIN);
  localparam logic [PW-1:0] SPAN     = PW'(DELAY_DEPTH * 256);
  localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);

  function automatic logic signed [ffdl_pkg::SAMP_W-1:0] sat16(
    input logic signed [21:0] v
  );
    if (v > 22'sd32767) return 16'sd32767;
    if (v < -22'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  ffdl_pkg::ctl_word_t ctl;

  logic in_accept, out_busy, out_load;

  // configuration
  logic signed [ffdl_pkg::SAMP_W-1:0] feedback_gain;
  logic [ffdl_pkg::SAMP_W-1:0]        mix_level;
  logic signed [ffdl_pkg::SAMP_W-1:0] fb_c;
  logic [ffdl_pkg::SAMP_W:0]          wet_c, dry_c;

  // datapath registers
  logic signed [ffdl_pkg::SAMP_W-1:0] samp_in;
  logic [ffdl_pkg::DELAY_W-1:0]       dly_raw;
  logic [AW+7:0]                      dly_clamp;
  logic [AW-1:0]                      base_addr, next_addr;
  logic [7:0]                         frac;
  logic                               rd_vld;
  logic signed [ffdl_pkg::ACC_W-1:0]  acc;
  logic signed [ffdl_pkg::SAMP_W-1:0] delayed;
  logic [AW-1:0]                      wi;
  logic                               wrapped;

  logic [CW-1:0]                      dly_ext;
  logic [PW-1:0]                      pos_raw, pos;
  logic [AW-1:0]                      pos_base;
  logic [AW-1:0]                      rd_addr;
  logic                               rd_en;
  logic signed [ffdl_pkg::SAMP_W-1:0] rdata, ram_val;
  logic signed [ffdl_pkg::OP1_W-1:0]  op1;
  logic signed [ffdl_pkg::OP2_W-1:0]  op2;
  logic signed [ffdl_pkg::OP1_W+ffdl_pkg::OP2_W-1:0] prod;
  logic signed [ffdl_pkg::ACC_W-1:0]  rnd_val;
  logic signed [ffdl_pkg::SAMP_W-1:0] acc_dly;
  logic signed [20:0]                 acc_q15;
  logic signed [ffdl_pkg::SAMP_W-1:0] stored;

  ffdl_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .ctl      (ctl)
  );

  assign in_ready  = (ctl.jc == ffdl_pkg::JC_IN);
  assign in_accept = in_valid && in_ready;
  assign out_busy  = out_valid && !out_ready;
  assign out_load  = ctl.ld_out && !out_busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= '0;
      mix_level     <= 16'd16384;
    end else if (cfg_valid) begin
      case (cfg_index)
        ffdl_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        ffdl_pkg::REG_MIX_LEVEL:     mix_level     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (feedback_gain > ffdl_pkg::FB_LIMIT) begin
      fb_c = ffdl_pkg::FB_LIMIT;
    end else if (feedback_gain < -ffdl_pkg::FB_LIMIT) begin
      fb_c = -ffdl_pkg::FB_LIMIT;
    end else begin
      fb_c = feedback_gain;
    end
    wet_c = ({1'b0, mix_level} > ffdl_pkg::MIX_ONE) ? ffdl_pkg::MIX_ONE : {1'b0, mix_level};
    dry_c = ffdl_pkg::MIX_ONE - wet_c;
  end

  // read position behind the write pointer, wrapped into the circular buffer
  assign dly_ext  = CW'(dly_raw);
  assign pos_raw  = {1'b0, wi, 8'b0} - {1'b0, dly_clamp};
  assign pos      = pos_raw[PW-1] ? pos_raw + SPAN : pos_raw;
  assign pos_base = pos[AW+7:8];

  always_ff @(posedge clk) begin
    if (in_accept) begin
      samp_in <= in_sample;
      dly_raw <= delay_q8;
    end
    if (ctl.ld_dc) begin
      if (dly_ext < DMIN_C) begin
        dly_clamp <= (AW+8)'(DMIN_C);
      end else if (dly_ext > DMAX) begin
        dly_clamp <= (AW+8)'(DMAX);
      end else begin
        dly_clamp <= (AW+8)'(dly_ext);
      end
    end
    if (ctl.ld_pos) begin
      base_addr <= pos_base;
      next_addr <= (pos_base == LAST_IDX) ? '0 : pos_base + 1'b1;
      frac      <= pos[7:0];
    end
  end

  assign rd_en   = (ctl.rd != ffdl_pkg::RD_NONE);
  assign rd_addr = (ctl.rd == ffdl_pkg::RD_NEXT) ? next_addr : base_addr;

  // entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld <= wrapped || (rd_addr < wi);
    end
  end

  assign ram_val = rd_vld ? rdata : '0;

  ffdl_ram #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_mem),
    .waddr (wi),
    .wdata (stored),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign acc_dly = acc[ffdl_pkg::SAMP_W+7:8];
  assign acc_q15 = acc[35:15];

  always_comb begin
    case (ctl.op1)
      ffdl_pkg::OP1_RAM:     op1 = ffdl_pkg::OP1_W'(ram_val);
      ffdl_pkg::OP1_ACC_DLY: op1 = ffdl_pkg::OP1_W'(acc_dly);
      ffdl_pkg::OP1_DLY:     op1 = ffdl_pkg::OP1_W'(delayed);
      ffdl_pkg::OP1_X:       op1 = ffdl_pkg::OP1_W'(samp_in);
      default:               op1 = '0;
    endcase
    case (ctl.op2)
      ffdl_pkg::OP2_INVF: op2 = $signed(ffdl_pkg::OP2_W'(9'd256 - {1'b0, frac}));
      ffdl_pkg::OP2_FRAC: op2 = $signed(ffdl_pkg::OP2_W'(frac));
      ffdl_pkg::OP2_FB:   op2 = ffdl_pkg::OP2_W'(fb_c);
      ffdl_pkg::OP2_DRY:  op2 = $signed(ffdl_pkg::OP2_W'(dry_c));
      ffdl_pkg::OP2_WET:  op2 = $signed(ffdl_pkg::OP2_W'(wet_c));
      default:            op2 = '0;
    endcase
    case (ctl.rnd)
      ffdl_pkg::RND_128: rnd_val = 36'sd128;
      ffdl_pkg::RND_16K: rnd_val = 36'sd16384;
      default:           rnd_val = '0;
    endcase
  end

  assign prod   = op1 * op2;
  assign stored = sat16(22'(samp_in) + 22'(acc_q15));

  always_ff @(posedge clk) begin
    if (ctl.mac) begin
      acc <= (ctl.acc_clr ? rnd_val : acc) + ffdl_pkg::ACC_W'(prod);
    end
    if (ctl.ld_dly) begin
      delayed <= acc_dly;
    end
    if (out_load) begin
      out_sample <= sat16(22'(acc_q15));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wi        <= '0;
      wrapped   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        if (wi == LAST_IDX) begin
          wi      <= '0;
          wrapped <= 1'b1;
        end else begin
          wi <= wi + 1'b1;
        end
      end
    end
  end

endmodule

[design/ffdl_checker.sv]
// Port-level checker for the flanger delay line, bound to the top level.
module ffdl_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [ffdl_pkg::SAMP_W-1:0] in_sample,
  input logic [ffdl_pkg::DELAY_W-1:0]       delay_q8,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ffdl_pkg::SAMP_W-1:0] out_sample,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input ffdl_pkg::cfg_reg_t                 cfg_index,
  input logic [ffdl_pkg::SAMP_W-1:0]        cfg_data
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("out_sample changed while stalled");

  // after reset: no result pending, ready for a request
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

  // one request at a time: in_ready is checked low at two points of the program after a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##7 !in_ready)
    else $error("request taken while busy");

  // a new result appears only as the program returns to idle
  a_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result without return to idle");

endmodule

bind feedback_flanger_delay_line ffdl_checker u_chk (.*);
